@@ hw/rtl/thr_pkg.sv @@
package thr_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam int COORD_W = 12;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

  localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST = 12'd320;
  localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 12'd240;

  localparam logic [2:0] CMD_DEFINE = 3'd0;
  localparam logic [2:0] CMD_TOUCH = 3'd1;
  localparam logic [2:0] CMD_ACTIVATE_ALL = 3'd2;
  localparam logic [2:0] CMD_DEACTIVATE_ALL = 3'd3;
  localparam logic [2:0] CMD_SET_ONE = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_CLAMP_RIGHT = 2'd1;
  localparam logic [1:0] ST_CLAMP_BOTTOM = 2'd2;

  typedef struct packed {
    logic [2:0]         command;
    logic [3:0]         entry_index;
    logic [11:0]        pos_x;
    logic [11:0]        pos_y;
    logic [7:0]         box_width;
    logic [7:0]         box_height;
    logic [7:0]         touch_border;
    logic signed [15:0] button_value;
    logic               active_flag;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               hit;
    logic [3:0]         hit_index;
    logic signed [15:0] hit_value;
    logic [11:0]        edge_right;
    logic [11:0]        edge_bottom;
  } rsp_t;

  typedef struct packed {
    logic [11:0]        left;
    logic [11:0]        top;
    logic [11:0]        right;
    logic [11:0]        bottom;
    logic [7:0]         margin;
    logic signed [15:0] payload;
  } entry_t;

  typedef struct packed {
    logic [11:0] edge_pos;
    logic        clamped;
  } far_edge_t;

  // Far edge of a span, clamped to one below the limit.
  function automatic far_edge_t far_edge(input logic [11:0] start, input logic [7:0] size,
                                         input logic [11:0] limit);
    logic [12:0] sz;
    logic [12:0] e;
    far_edge_t   res;
    sz = (size == 8'd0) ? 13'd1 : {5'd0, size};
    e = {1'b0, start} + sz - 13'd1;
    res.clamped = (e >= {1'b0, limit});
    if (res.clamped) begin
      res.edge_pos = (limit == 12'd0) ? 12'd0 : limit - 12'd1;
    end else begin
      res.edge_pos = e[11:0];
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/touch_region_hit_table_top.sv @@
// Touch rectangle table. A define, activate-all, deactivate-all or set-one
// request is taken at once and its result appears on the following
// cycle; busy stays low, so such requests may be issued back to back. A touch
// check holds busy until its scan ends at the first hit or after the last
// entry: the rectangle memory has one read port and the scan reads one entry
// per cycle, comparing each on its registered read data. The result is
// presented for exactly one cycle with done high and cannot be held off, so
// the receiver must capture it on that cycle. Screen size registers may be
// written at any time the block is idle.
module touch_region_hit_table_top #(
  parameter int MAX_ENTRIES = thr_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  thr_pkg::req_t                         request,
  output logic                                  done,
  output thr_pkg::rsp_t                         result,
  input  logic                                  cfg_wr_en,
  input  logic [thr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [thr_pkg::CFG_DATA_W-1:0]        cfg_data
);

  import thr_pkg::*;

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);
  localparam int EW = $bits(entry_t);

  typedef enum logic {IDLE, SCAN} state_t;

  state_t                 state;
  logic [COORD_W-1:0]     screen_width;
  logic [COORD_W-1:0]     screen_height;
  logic [MAX_ENTRIES-1:0] entry_valid;
  logic [MAX_ENTRIES-1:0] entry_active;
  logic [IW-1:0]          scan_idx;
  logic                   issue_done;
  logic                   cmp_vld;
  logic [IW-1:0]          cmp_idx;
  logic [COORD_W-1:0]     touch_x;
  logic [COORD_W-1:0]     touch_y;

  logic                   accept;
  logic [IW+3:0]          idx_wide;
  logic                   idx_ok;
  logic [IW-1:0]          idx;
  far_edge_t              fe_x;
  far_edge_t              fe_y;
  entry_t                 new_entry;
  logic                   wr_en;
  logic                   issue;
  entry_t                 rd_entry;
  logic [EW-1:0]          rd_bits;
  logic [12:0]            lo_x;
  logic [12:0]            lo_y;
  logic [12:0]            hi_x;
  logic [12:0]            hi_y;
  logic                   match;
  logic                   scan_end;
  rsp_t                   define_rsp;
  rsp_t                   scan_rsp;

  assign accept = start && !busy;
  assign busy = (state != IDLE);

  assign idx_wide = (IW + 4)'(request.entry_index);
  assign idx_ok = idx_wide < (IW + 4)'(MAX_ENTRIES);
  assign idx = idx_wide[IW-1:0];

  assign fe_x = far_edge(request.pos_x, request.box_width, screen_width);
  assign fe_y = far_edge(request.pos_y, request.box_height, screen_height);

  always_comb begin
    new_entry.left = request.pos_x;
    new_entry.top = request.pos_y;
    new_entry.right = fe_x.edge_pos;
    new_entry.bottom = fe_y.edge_pos;
    new_entry.margin = request.touch_border;
    new_entry.payload = request.button_value;
  end

  // Result of a request that answers at once; all zero unless it is a define with a valid index.
  always_comb begin
    define_rsp = '0;
    if ((request.command == CMD_DEFINE) && idx_ok) begin
      define_rsp.edge_right = fe_x.edge_pos;
      define_rsp.edge_bottom = fe_y.edge_pos;
      // A bottom clamp takes precedence over a right clamp.
      if (fe_y.clamped) begin
        define_rsp.status = ST_CLAMP_BOTTOM;
      end else if (fe_x.clamped) begin
        define_rsp.status = ST_CLAMP_RIGHT;
      end else begin
        define_rsp.status = ST_OK;
      end
    end
  end

  assign wr_en = accept && (request.command == CMD_DEFINE) && idx_ok;
  assign issue = (state == SCAN) && !issue_done;

  thr_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_ENTRIES)
  ) u_entry_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(idx),
    .wr_data(new_entry),
    .rd_en  (issue),
    .rd_addr(scan_idx),
    .rd_data(rd_bits)
  );

  assign rd_entry = entry_t'(rd_bits);

  // Rectangle grown by the margin; the near edges stop at zero.
  always_comb begin
    lo_x = ({5'd0, rd_entry.margin} > {1'b0, rd_entry.left}) ? 13'd0 :
           {1'b0, rd_entry.left} - {5'd0, rd_entry.margin};
    lo_y = ({5'd0, rd_entry.margin} > {1'b0, rd_entry.top}) ? 13'd0 :
           {1'b0, rd_entry.top} - {5'd0, rd_entry.margin};
    hi_x = {1'b0, rd_entry.right} + {5'd0, rd_entry.margin};
    hi_y = {1'b0, rd_entry.bottom} + {5'd0, rd_entry.margin};
    match = entry_valid[cmp_idx] && entry_active[cmp_idx] &&
            ({1'b0, touch_x} >= lo_x) && ({1'b0, touch_x} <= hi_x) &&
            ({1'b0, touch_y} >= lo_y) && ({1'b0, touch_y} <= hi_y);
  end

  assign scan_end = cmp_vld && (match || (cmp_idx == LAST_IDX));

  always_comb begin
    scan_rsp = '0;
    if (match) begin
      scan_rsp.hit = 1'b1;
      scan_rsp.hit_index = 4'(cmp_idx);
      scan_rsp.hit_value = rd_entry.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done <= 1'b0;
      result <= '0;
      screen_width <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
      entry_valid <= '0;
      entry_active <= '0;
      scan_idx <= '0;
      issue_done <= 1'b0;
      cmp_vld <= 1'b0;
      cmp_idx <= '0;
      touch_x <= '0;
      touch_y <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_SCREEN_WIDTH:  screen_width <= cfg_data;
          CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        IDLE: begin
          done <= accept && (request.command != CMD_TOUCH);
          if (accept) begin
            result <= define_rsp;
            unique case (request.command)
              CMD_DEFINE: begin
                if (idx_ok) begin
                  entry_valid[idx] <= 1'b1;
                end
              end
              CMD_TOUCH: begin
                state <= SCAN;
                touch_x <= request.pos_x;
                touch_y <= request.pos_y;
                scan_idx <= '0;
                issue_done <= 1'b0;
                cmp_vld <= 1'b0;
              end
              CMD_ACTIVATE_ALL:   entry_active <= '1;
              CMD_DEACTIVATE_ALL: entry_active <= '0;
              CMD_SET_ONE: begin
                if (idx_ok) begin
                  entry_active[idx] <= request.active_flag;
                end
              end
              default: ;
            endcase
          end
        end
        SCAN: begin
          done <= scan_end;
          if (scan_end) begin
            state <= IDLE;
            cmp_vld <= 1'b0;
            result <= scan_rsp;
          end else begin
            cmp_vld <= issue;
            cmp_idx <= scan_idx;
            if (issue) begin
              if (scan_idx == LAST_IDX) begin
                issue_done <= 1'b1;
              end else begin
                scan_idx <= scan_idx + IW'(1);
              end
            end
          end
        end
        default: begin
          state <= IDLE;
          done <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/thr_ram.sv @@
module thr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/thr_checker.sv @@
module thr_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input thr_pkg::req_t request,
  input logic          done,
  input thr_pkg::rsp_t result
);

  import thr_pkg::*;

  // A result is never shown while a scan is still running.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Every request other than a touch check answers on the next cycle.
  a_quick_reply: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.command != CMD_TOUCH) |=> (done && !busy))
    else $error("missing one-cycle reply");

  // A touch check raises busy until its scan ends.
  a_touch_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.command == CMD_TOUCH) |=> (busy && !done))
    else $error("touch check did not start a scan");

  // Define fields and touch fields never mix in one result.
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    (done && result.hit) |->
      (result.status == ST_OK && result.edge_right == '0 && result.edge_bottom == '0))
    else $error("hit result carries define fields");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.hit) |-> (result.hit_index == '0 && result.hit_value == '0))
    else $error("miss result carries hit fields");

endmodule

bind touch_region_hit_table_top thr_checker u_thr_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .request(request),
  .done   (done),
  .result (result)
);
